>>> sv/swts_pkg.sv
`default_nettype none

package swts_pkg;

  // event kinds on the request channel
  localparam logic [1:0] CMD_START   = 2'd0;
  localparam logic [1:0] CMD_REPLY   = 2'd1;
  localparam logic [1:0] CMD_NOREPLY = 2'd2;
  localparam logic [1:0] CMD_TICK    = 2'd3;

  // reply kinds; anything else counts as "other"
  localparam logic [1:0] REPLY_ACK = 2'd0;
  localparam logic [1:0] REPLY_EOT = 2'd1;

  // frame to send
  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_SOT  = 2'd1;
  localparam logic [1:0] ACT_DATA = 2'd2;
  localparam logic [1:0] ACT_EOT  = 2'd3;

  // transfer phase
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_OPEN = 2'd1;
  localparam logic [1:0] PH_SEND = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_TRANSFER_BYTES  = 2'd0;
  localparam logic [1:0] REG_CHUNK_BYTES     = 2'd1;
  localparam logic [1:0] REG_TIMEOUT_SECONDS = 2'd2;
  localparam logic [1:0] REG_SESSION_ID      = 2'd3;

  localparam logic [31:0] TRANSFER_BYTES_RST  = 32'd0;
  localparam logic [15:0] CHUNK_BYTES_RST     = 16'd1024;
  localparam logic [15:0] TIMEOUT_SECONDS_RST = 16'd10;

  localparam logic [15:0] SECONDS_MAX = 16'hFFFF;

  typedef struct packed {
    logic [31:0] transfer_bytes;
    logic [15:0] chunk_bytes;
    logic [15:0] timeout_seconds;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] packet_number;
    logic [31:0] byte_offset;
    logic [15:0] byte_count;
    logic        finished;
    logic        succeeded;
  } res_t;

endpackage

`default_nettype wire

>>> sv/swts_cfg.sv
`default_nettype none

module swts_cfg (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               wr_en,
  input  wire logic [1:0]         wr_index,
  input  wire logic [31:0]        wr_data,
  output swts_pkg::cfg_t          cfg
);

  swts_pkg::cfg_t cfg_r;
  swts_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        swts_pkg::REG_TRANSFER_BYTES:  cfg_nxt.transfer_bytes  = wr_data;
        swts_pkg::REG_CHUNK_BYTES:     cfg_nxt.chunk_bytes     = wr_data[15:0];
        swts_pkg::REG_TIMEOUT_SECONDS: cfg_nxt.timeout_seconds = wr_data[15:0];
        // session number only matters to the framer downstream
        swts_pkg::REG_SESSION_ID:      cfg_nxt = cfg_r;
        default:                       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.transfer_bytes  <= swts_pkg::TRANSFER_BYTES_RST;
      cfg_r.chunk_bytes     <= swts_pkg::CHUNK_BYTES_RST;
      cfg_r.timeout_seconds <= swts_pkg::TIMEOUT_SECONDS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

>>> sv/swts_core.sv
`default_nettype none

module swts_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               req_en,
  input  wire logic [1:0]         cmd,
  input  wire logic [1:0]         reply_code,
  input  wire logic [31:0]        reply_number,
  input  wire swts_pkg::cfg_t     cfg,
  output logic                    res_en,
  output swts_pkg::res_t          res
);

  logic [1:0]  phase_r, phase_nxt;
  logic [31:0] pkt_r, pkt_nxt;
  logic [31:0] acked_r, acked_nxt;
  logic [15:0] elapsed_r, elapsed_nxt;

  logic        active;
  logic [32:0] rem_diff;
  logic [31:0] rem;
  logic [15:0] len;
  logic        ack_done;
  logic [31:0] rem_after;
  logic [15:0] len_after;
  logic [31:0] acked_inc;
  logic [15:0] elapsed_inc;
  logic        emit;
  swts_pkg::res_t out;

  assign active = (phase_r == swts_pkg::PH_OPEN) || (phase_r == swts_pkg::PH_SEND);

  // bytes still to go and size of the current chunk
  assign rem_diff = {1'b0, cfg.transfer_bytes} - {1'b0, acked_r};
  assign rem      = rem_diff[32] ? 32'd0 : rem_diff[31:0];
  assign len      = (rem < {16'd0, cfg.chunk_bytes}) ? rem[15:0] : cfg.chunk_bytes;

  // after an ACK of a full chunk the next chunk is min(rem - chunk, chunk)
  assign ack_done  = (rem <= {16'd0, cfg.chunk_bytes});
  assign rem_after = rem - {16'd0, cfg.chunk_bytes};
  assign len_after = (rem_after < {16'd0, cfg.chunk_bytes}) ? rem_after[15:0]
                                                             : cfg.chunk_bytes;
  assign acked_inc = acked_r + {16'd0, len};

  assign elapsed_inc = (elapsed_r == swts_pkg::SECONDS_MAX) ? elapsed_r
                                                            : elapsed_r + 16'd1;

  always_comb begin
    phase_nxt   = phase_r;
    pkt_nxt     = pkt_r;
    acked_nxt   = acked_r;
    elapsed_nxt = elapsed_r;
    emit        = 1'b0;
    out         = '0;
    unique case (cmd)
      swts_pkg::CMD_START: begin
        if (!active) begin
          pkt_nxt     = 32'd0;
          acked_nxt   = 32'd0;
          elapsed_nxt = 16'd0;
          emit        = 1'b1;
          if (cfg.transfer_bytes == 32'd0) begin
            phase_nxt     = swts_pkg::PH_DONE;
            out.action    = swts_pkg::ACT_EOT;
            out.finished  = 1'b1;
            out.succeeded = 1'b1;
          end else begin
            phase_nxt  = swts_pkg::PH_OPEN;
            out.action = swts_pkg::ACT_SOT;
          end
        end
      end
      swts_pkg::CMD_TICK: begin
        if (active) begin
          elapsed_nxt = elapsed_inc;
          if (elapsed_inc > cfg.timeout_seconds) begin
            phase_nxt    = swts_pkg::PH_DONE;
            emit         = 1'b1;
            out.action   = swts_pkg::ACT_NONE;
            out.finished = 1'b1;
          end
        end
      end
      default: begin
        if (phase_r == swts_pkg::PH_OPEN) begin
          emit = 1'b1;
          if (cmd == swts_pkg::CMD_REPLY && reply_code == swts_pkg::REPLY_ACK) begin
            pkt_nxt           = 32'd0;
            phase_nxt         = swts_pkg::PH_SEND;
            out.action        = swts_pkg::ACT_DATA;
            out.packet_number = 32'd0;
            out.byte_offset   = acked_r;
            out.byte_count    = len;
          end else begin
            out.action = swts_pkg::ACT_SOT;
          end
        end else if (phase_r == swts_pkg::PH_SEND) begin
          emit = 1'b1;
          if (cmd == swts_pkg::CMD_REPLY && reply_code == swts_pkg::REPLY_ACK &&
              reply_number == pkt_r) begin
            acked_nxt = acked_inc;
            pkt_nxt   = pkt_r + 32'd1;
            if (ack_done) begin
              phase_nxt     = swts_pkg::PH_DONE;
              out.action    = swts_pkg::ACT_EOT;
              out.finished  = 1'b1;
              out.succeeded = 1'b1;
            end else begin
              out.action        = swts_pkg::ACT_DATA;
              out.packet_number = pkt_r + 32'd1;
              out.byte_offset   = acked_inc;
              out.byte_count    = len_after;
            end
          end else if (cmd == swts_pkg::CMD_REPLY &&
                       reply_code == swts_pkg::REPLY_EOT) begin
            phase_nxt    = swts_pkg::PH_DONE;
            out.action   = swts_pkg::ACT_NONE;
            out.finished = 1'b1;
          end else begin
            // resend the current packet
            out.action        = swts_pkg::ACT_DATA;
            out.packet_number = pkt_r;
            out.byte_offset   = acked_r;
            out.byte_count    = len;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= swts_pkg::PH_IDLE;
      pkt_r     <= 32'd0;
      acked_r   <= 32'd0;
      elapsed_r <= 16'd0;
    end else if (req_en) begin
      phase_r   <= phase_nxt;
      pkt_r     <= pkt_nxt;
      acked_r   <= acked_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

  assign res_en = req_en & emit;
  assign res    = out;

endmodule

`default_nettype wire

>>> sv/swts_obuf.sv
`default_nettype none

module swts_obuf (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire swts_pkg::res_t     push_data,
  output logic                    space,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output swts_pkg::res_t          out_data
);

  logic           main_valid_r, main_valid_nxt;
  logic           skid_valid_r, skid_valid_nxt;
  swts_pkg::res_t main_data_r, main_data_nxt;
  swts_pkg::res_t skid_data_r, skid_data_nxt;
  logic           pop;

  assign pop = main_valid_r & out_ready;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_data_nxt  = main_data_r;
    skid_data_nxt  = skid_data_r;
    if (!main_valid_r || pop) begin
      if (skid_valid_r) begin
        main_valid_nxt = 1'b1;
        main_data_nxt  = skid_data_r;
        skid_valid_nxt = push;
        skid_data_nxt  = push_data;
      end else begin
        main_valid_nxt = push;
        main_data_nxt  = push_data;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_data_r <= main_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign space     = ~skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_data_r;

endmodule

`default_nettype wire

>>> sv/stop_and_wait_transfer_sender_unit.sv
`default_nettype none

// channel   dir  handshake                 payload
// in_       in   in_tvalid / in_tready     tuser: cmd, reply_code; tdata: reply_number
// out_      out  out_tvalid / out_tready   tuser: action; tdata: packet_number,
//                                          byte_offset, byte_count, succeeded;
//                                          tlast: finished
// cfg_      in   cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One request per cycle while in_tready is high: the decision is made in the
// cycle the request is taken and the transfer state is updated at that same
// edge. Each result is registered in the output stage before it is on out_.
// Reset (rst_n low, synchronous) returns the phase to idle, clears counters
// and empties the output stage; config registers take their reset values.
// A two-entry output stage (result register plus skid) keeps in_tready high
// while one result waits; in_tready drops only when both entries are full.
// cfg_ready is always high; session_id writes are accepted and dropped.

module stop_and_wait_transfer_sender_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [3:0]  in_tuser,   // [1:0] cmd, [3:2] reply_code
  input  wire logic [31:0] in_tdata,   // [31:0] reply_number

  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [1:0]       out_tuser,  // [1:0] action
  output logic [87:0]      out_tdata,  // [31:0] packet_number, [63:32] byte_offset,
                                       // [79:64] byte_count, [80] succeeded, rest 0
  output logic             out_tlast,  // finished

  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  swts_pkg::cfg_t cfg;
  swts_pkg::res_t core_res;
  swts_pkg::res_t obuf_res;
  logic           core_res_en;
  logic           obuf_space;
  logic           req_en;

  assign cfg_ready = 1'b1;

  swts_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // request accepted this edge
  assign in_tready = obuf_space;
  assign req_en    = in_tvalid & in_tready;

  swts_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_en       (req_en),
    .cmd          (in_tuser[1:0]),
    .reply_code   (in_tuser[3:2]),
    .reply_number (in_tdata),
    .cfg          (cfg),
    .res_en       (core_res_en),
    .res          (core_res)
  );

  swts_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (core_res_en),
    .push_data (core_res),
    .space     (obuf_space),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (obuf_res)
  );

  assign out_tuser = obuf_res.action;
  assign out_tlast = obuf_res.finished;
  assign out_tdata = {7'd0, obuf_res.succeeded, obuf_res.byte_count,
                      obuf_res.byte_offset, obuf_res.packet_number};

  // a full skid entry means the result register is also holding one
  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("skid entry held while result register empty");

  // success is only ever reported with the end frame and the end of transfer
  a_success_eot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[80]) |-> (out_tlast && out_tuser == swts_pkg::ACT_EOT))
    else $error("success reported without end frame");

  // a result with no frame is always a failed end of transfer
  a_none_is_fail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == swts_pkg::ACT_NONE) |-> (out_tlast && !out_tdata[80]))
    else $error("empty action on a result that does not end the transfer");

  // a data packet never ends the transfer
  a_data_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == swts_pkg::ACT_DATA) |-> !out_tlast)
    else $error("data packet marked as end of transfer");

endmodule

`default_nettype wire

>>> bench/tb_stop_and_wait_transfer_sender_unit.sv
`timescale 1ns / 1ps

module tb_stop_and_wait_transfer_sender_unit;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 200;  // long receiver hold-off, fills the output stage
  localparam int DRAIN_CYCLES = 4;    // margin after the last expected result is taken
  localparam int PHASES       = 16;
  localparam int PHASE_ITEMS  = 100;

  // Tracks the sender's transfer state, predicts the frame each request asks
  // for and keeps the predicted frames in request order.
  class frame_scoreboard;
    logic [31:0]    total_bytes;
    logic [15:0]    chunk_size;
    logic [15:0]    timeout_sec;
    logic [1:0]     phase;
    logic [31:0]    cur_packet;
    logic [31:0]    acked_bytes;
    logic [15:0]    seconds;
    swts_pkg::res_t expected_frames[$];
    int             errors;

    function new();
      total_bytes = swts_pkg::TRANSFER_BYTES_RST;
      chunk_size  = swts_pkg::CHUNK_BYTES_RST;
      timeout_sec = swts_pkg::TIMEOUT_SECONDS_RST;
      phase       = swts_pkg::PH_IDLE;
      cur_packet  = '0;
      acked_bytes = '0;
      seconds     = '0;
      errors      = 0;
    endfunction

    function void set_register(logic [1:0] idx, logic [31:0] value);
      case (idx)
        swts_pkg::REG_TRANSFER_BYTES:  total_bytes = value;
        swts_pkg::REG_CHUNK_BYTES:     chunk_size  = value[15:0];
        swts_pkg::REG_TIMEOUT_SECONDS: timeout_sec = value[15:0];
        default: ;  // session id only matters to the framer
      endcase
    endfunction

    // payload of the current packet: remaining bytes, capped at the chunk size
    function logic [15:0] chunk_len();
      logic [31:0] remaining;
      remaining = (total_bytes > acked_bytes) ? total_bytes - acked_bytes : 32'd0;
      return (remaining < {16'd0, chunk_size}) ? remaining[15:0] : chunk_size;
    endfunction

    function swts_pkg::res_t data_frame();
      swts_pkg::res_t r;
      r = '0;
      r.action        = swts_pkg::ACT_DATA;
      r.packet_number = cur_packet;
      r.byte_offset   = acked_bytes;
      r.byte_count    = chunk_len();
      return r;
    endfunction

    // Returns 1 unless the request is ignored by the sender.
    function bit predict_frame(logic [1:0] cmd, logic [1:0] code, logic [31:0] num);
      swts_pkg::res_t r;
      bit             active;
      bit             emit;
      r      = '0;
      emit   = 1'b1;
      active = (phase == swts_pkg::PH_OPEN) || (phase == swts_pkg::PH_SEND);
      if (cmd == swts_pkg::CMD_START) begin
        if (active) return 1'b0;
        cur_packet  = '0;
        acked_bytes = '0;
        seconds     = '0;
        if (total_bytes == 32'd0) begin
          phase       = swts_pkg::PH_DONE;
          r.action    = swts_pkg::ACT_EOT;
          r.finished  = 1'b1;
          r.succeeded = 1'b1;
        end else begin
          phase    = swts_pkg::PH_OPEN;
          r.action = swts_pkg::ACT_SOT;
        end
      end else if (!active) begin
        return 1'b0;
      end else if (cmd == swts_pkg::CMD_TICK) begin
        if (seconds != swts_pkg::SECONDS_MAX) seconds++;
        emit = 1'b0;
        if (seconds > timeout_sec) begin
          phase      = swts_pkg::PH_DONE;
          r.finished = 1'b1;
          emit       = 1'b1;
        end
      end else if (phase == swts_pkg::PH_OPEN) begin
        if (cmd == swts_pkg::CMD_REPLY && code == swts_pkg::REPLY_ACK) begin
          cur_packet = '0;
          phase      = swts_pkg::PH_SEND;
          r          = data_frame();
        end else begin
          r.action = swts_pkg::ACT_SOT;
        end
      end else if (cmd == swts_pkg::CMD_REPLY && code == swts_pkg::REPLY_ACK &&
                   num == cur_packet) begin
        acked_bytes = acked_bytes + {16'd0, chunk_len()};
        cur_packet  = cur_packet + 32'd1;
        if (acked_bytes >= total_bytes) begin
          phase       = swts_pkg::PH_DONE;
          r.action    = swts_pkg::ACT_EOT;
          r.finished  = 1'b1;
          r.succeeded = 1'b1;
        end else begin
          r = data_frame();
        end
      end else if (cmd == swts_pkg::CMD_REPLY && code == swts_pkg::REPLY_EOT) begin
        phase      = swts_pkg::PH_DONE;
        r.finished = 1'b1;
      end else begin
        r = data_frame();
      end
      if (emit) expected_frames.push_back(r);
      return 1'b1;
    endfunction

    function void field_check(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_frame(logic [1:0] action, logic [87:0] data, logic fin);
      swts_pkg::res_t want;
      if (expected_frames.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, expected nothing, actual %0h/%0h/%0b",
                 $time, action, data, fin);
        return;
      end
      want = expected_frames.pop_front();
      field_check("action", 32'(want.action), 32'(action));
      field_check("packet_number", want.packet_number, data[31:0]);
      field_check("byte_offset", want.byte_offset, data[63:32]);
      field_check("byte_count", 32'(want.byte_count), 32'(data[79:64]));
      field_check("succeeded", 32'(want.succeeded), 32'(data[80]));
      field_check("tdata padding", 32'd0, 32'(data[87:81]));
      field_check("finished", 32'(want.finished), 32'(fin));
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [3:0]  in_tuser   = '0;    // [1:0] cmd, [3:2] reply_code
  logic [31:0] in_tdata   = '0;    // [31:0] reply_number
  logic        out_tready = 1'b0;
  logic        cfg_valid  = 1'b0;
  logic [1:0]  cfg_index  = '0;
  logic [31:0] cfg_data   = '0;
  wire         in_tready;
  wire         out_tvalid;
  wire  [1:0]  out_tuser;          // [1:0] action
  wire  [87:0] out_tdata;          // [31:0] packet_number, [63:32] byte_offset,
                                   // [79:64] byte_count, [80] succeeded
  wire         out_tlast;          // finished
  wire         cfg_ready;

  frame_scoreboard sb = new();

  int idle_pct = 37;   // chance in 100 that a side idles; 0 gives a stretch with no gaps
  bit hold_go  = 1'b0; // asks the receiver for a long hold-off
  int hold_cnt = 0;
  bit offering = 1'b0; // in_tvalid is (being) driven high
  int acted    = 0;    // requests the sender did not ignore
  int cycles   = 0;

  stop_and_wait_transfer_sender_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tuser (out_tuser),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial forever #2 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: checks every taken result, stalls at random, and on request
  // holds off for HOLD_CYCLES so the two-entry output stage fills and the
  // block drops in_tready.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_frame(out_tuser, out_tdata, out_tlast);
    if (hold_go) begin
      hold_cnt = HOLD_CYCLES;
      hold_go  = 1'b0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= idle_pct);
    end
  end

  // One request: offer it until taken, feed the predictor, then maybe idle.
  // Each idle cycle is drawn on its own, so about idle_pct cycles in a
  // hundred are idle. in_tvalid stays high into the next request when no
  // gap is drawn.
  task automatic send_request(logic [1:0] cmd, logic [1:0] code, logic [31:0] num);
    in_tvalid <= 1'b1;
    in_tuser  <= {code, cmd};
    in_tdata  <= num;
    offering = 1'b1;
    do @(posedge clk); while (!in_tready);
    if (sb.predict_frame(cmd, code, num)) acted++;
    if ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      offering = 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
  endtask

  // Sender pause: stop offering and let every expected result come out.
  task automatic wait_quiet();
    if (offering) begin
      in_tvalid <= 1'b0;
      offering = 1'b0;
    end
    while (sb.expected_frames.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // cfg_valid stays high across back-to-back writes; cfg_close lowers it.
  task automatic cfg_write(logic [1:0] idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.set_register(idx, value);
  endtask

  task automatic cfg_close();
    cfg_valid <= 1'b0;
  endtask

  // Register settings per phase: the first few are fixed corners, the rest
  // random with mostly small transfers so that many complete.
  task automatic configure_phase(int k);
    logic [31:0] total, chunk, limit, session;
    bit          write_all;
    write_all = (k < 4);
    session   = $urandom;
    case (k)
      0: begin  // largest everything: only a peer EOT ends a transfer
        total = 32'hFFFF_FFFF; chunk = 32'hFFFF; limit = 32'hFFFF; session = 32'hFFFF;
      end
      1: begin  // zero chunk and zero timeout: first tick fails
        total = $urandom_range(1, 5000); chunk = 32'd0; limit = 32'd0;
      end
      2: begin  // one-byte transfer
        total = 32'd1; chunk = 32'd1; limit = 32'd3; session = 32'd0;
      end
      3: begin  // empty transfers only
        total = 32'd0; chunk = $urandom_range(1, 65535); limit = $urandom_range(0, 5);
      end
      default: begin
        case ($urandom_range(0, 9))
          8:       total = $urandom;
          9:       total = 32'd0;
          default: total = $urandom_range(1, 4000);
        endcase
        case ($urandom_range(0, 9))
          8:       chunk = 32'hFFFF;
          9:       chunk = $urandom_range(0, 65535);
          default: chunk = $urandom_range(1, 600);
        endcase
        case ($urandom_range(0, 9))
          8:       limit = 32'hFFFF;
          9:       limit = $urandom_range(0, 65535);
          default: limit = $urandom_range(2, 40);
        endcase
        // upper bits of the 16-bit registers are dropped by the block
        if ($urandom_range(0, 4) == 0) chunk[31:16] = 16'($urandom);
        if ($urandom_range(0, 4) == 0) limit[31:16] = 16'($urandom);
      end
    endcase
    if (write_all || $urandom_range(0, 9) < 6)
      cfg_write(swts_pkg::REG_TRANSFER_BYTES, total);
    if (write_all || $urandom_range(0, 9) < 6)
      cfg_write(swts_pkg::REG_CHUNK_BYTES, chunk);
    if (write_all || $urandom_range(0, 9) < 6)
      cfg_write(swts_pkg::REG_TIMEOUT_SECONDS, limit);
    if (write_all || $urandom_range(0, 9) < 6)
      cfg_write(swts_pkg::REG_SESSION_ID, session);
    cfg_close();
  endtask

  // Mostly well-formed exchanges (start, matching ACKs) with some lost,
  // wrong and aborting replies, ticks and plain noise mixed in.
  task automatic next_request();
    int          pick;
    logic [1:0]  cmd;
    logic [1:0]  code;
    logic [31:0] num;
    pick = $urandom_range(0, 99);
    cmd  = 2'($urandom_range(0, 3));
    code = 2'($urandom_range(0, 3));
    num  = $urandom;
    if (sb.phase == swts_pkg::PH_IDLE || sb.phase == swts_pkg::PH_DONE) begin
      if (pick < 75) cmd = swts_pkg::CMD_START;
    end else if (sb.phase == swts_pkg::PH_OPEN) begin
      if (pick < 75) begin
        cmd  = swts_pkg::CMD_REPLY;
        code = swts_pkg::REPLY_ACK;
      end
    end else begin
      if (pick < 72) begin
        cmd  = swts_pkg::CMD_REPLY;
        code = swts_pkg::REPLY_ACK;
        num  = sb.cur_packet;
      end else if (pick < 80) begin  // ACK of the wrong packet
        cmd  = swts_pkg::CMD_REPLY;
        code = swts_pkg::REPLY_ACK;
        num  = sb.cur_packet ^ (32'd1 << $urandom_range(0, 31));
      end else if (pick < 84) begin
        cmd  = swts_pkg::CMD_REPLY;
        code = swts_pkg::REPLY_EOT;
      end else if (pick < 90) begin
        cmd = swts_pkg::CMD_TICK;
      end
    end
    send_request(cmd, code, num);
  endtask

  initial begin
    int k;
    int target;
    bit paused;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // events before any transfer are ignored; start with zero bytes ends at once
    send_request(swts_pkg::CMD_REPLY, swts_pkg::REPLY_ACK, 32'd0);
    send_request(swts_pkg::CMD_TICK, 2'd0, 32'd0);
    send_request(swts_pkg::CMD_NOREPLY, 2'd0, 32'hFFFF_FFFF);
    send_request(swts_pkg::CMD_START, 2'd0, 32'd0);
    send_request(swts_pkg::CMD_REPLY, swts_pkg::REPLY_ACK, 32'd0);

    wait_quiet();
    cfg_write(swts_pkg::REG_TRANSFER_BYTES, 32'd3000);
    cfg_write(swts_pkg::REG_CHUNK_BYTES, 32'd1024);
    cfg_write(swts_pkg::REG_TIMEOUT_SECONDS, 32'd2);
    cfg_write(swts_pkg::REG_SESSION_ID, 32'hFFFF);
    cfg_close();

    // opening: second start ignored, anything but ACK resends the start frame
    send_request(swts_pkg::CMD_START, 2'd0, 32'd0);
    send_request(swts_pkg::CMD_START, 2'd0, 32'd0);
    send_request(swts_pkg::CMD_REPLY, swts_pkg::REPLY_EOT, 32'd0);
    send_request(swts_pkg::CMD_REPLY, 2'd2, 32'd0);
    send_request(swts_pkg::CMD_REPLY, 2'd3, 32'hFFFF_FFFF);
    send_request(swts_pkg::CMD_NOREPLY, 2'd0, 32'd0);
    // any ACK number opens data; wrong number, other reply, lost reply resend
    send_request(swts_pkg::CMD_REPLY, swts_pkg::REPLY_ACK, 32'hFFFF_FFFF);
    send_request(swts_pkg::CMD_REPLY, swts_pkg::REPLY_ACK, 32'd1);
    send_request(swts_pkg::CMD_REPLY, 2'd2, 32'd0);
    send_request(swts_pkg::CMD_NOREPLY, 2'd0, 32'd0);
    send_request(swts_pkg::CMD_REPLY, swts_pkg::REPLY_ACK, 32'd0);
    send_request(swts_pkg::CMD_REPLY, swts_pkg::REPLY_ACK, 32'd1);  // short last chunk follows
    send_request(swts_pkg::CMD_TICK, 2'd0, 32'd0);
    send_request(swts_pkg::CMD_TICK, 2'd0, 32'd0);        // at the limit, not past it
    send_request(swts_pkg::CMD_REPLY, swts_pkg::REPLY_ACK, 32'd2);  // all bytes acked
    // restart after the end, then run out of time
    send_request(swts_pkg::CMD_START, 2'd0, 32'd0);
    send_request(swts_pkg::CMD_TICK, 2'd0, 32'd0);
    send_request(swts_pkg::CMD_TICK, 2'd0, 32'd0);
    send_request(swts_pkg::CMD_TICK, 2'd0, 32'd0);
    // peer aborts mid-transfer
    send_request(swts_pkg::CMD_START, 2'd0, 32'd0);
    send_request(swts_pkg::CMD_REPLY, swts_pkg::REPLY_ACK, 32'd7);
    send_request(swts_pkg::CMD_REPLY, swts_pkg::REPLY_EOT, 32'd0);

    for (k = 0; k < PHASES; k++) begin
      // registers change only with nothing in flight; the transfer itself
      // may be mid-way, so changes also land between packets
      wait_quiet();
      configure_phase(k);
      idle_pct = (k == 6) ? 0 : 37;
      if (k == 9) hold_go = 1'b1;
      paused = 1'b0;
      target = acted + PHASE_ITEMS;
      while (acted < target) begin
        if (k == 11 && !paused && acted >= target - PHASE_ITEMS / 2) begin
          wait_quiet();
          paused = 1'b1;
        end
        next_request();
      end
    end

    idle_pct = 37;
    wait_quiet();
    if (sb.errors == 0 && sb.expected_frames.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/swts_pkg.sv
sv/swts_cfg.sv
sv/swts_core.sv
sv/swts_obuf.sv
sv/stop_and_wait_transfer_sender_unit.sv
bench/tb_stop_and_wait_transfer_sender_unit.sv
